FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication violated");

// Consequent must hold in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle property violated");

// Next-cycle check that also applies while reset is asserted.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle property violated");

`endif

FILE: hw/rtl/nsc_pkg.sv
// ----------------------------------------------------------------------------
// nsc_pkg
// Types, constants and helper functions of the NMEA sentence checker.
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam int TAG_CHARS = 5;
    localparam int TAG_W     = 40;
    localparam int TAG_BYTES = TAG_W / 8;
    localparam int POS_W     = $clog2(TAG_CHARS + 1);

    localparam logic [TAG_W-1:0] TAG_RESET = 40'h4750474741;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_DATA = 3'd1,
        PH_HI   = 3'd2,
        PH_LO   = 3'd3,
        PH_CR   = 3'd4,
        PH_LF   = 3'd5
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // Decode one ASCII hex digit; an invalid digit decodes to zero.
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            h.ok  = 1'b1;
            h.val = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            h.ok  = 1'b1;
            h.val = c[3:0] + 4'd9;
        end
        return h;
    endfunction

    // Expected tag character at sentence position pos. The first character
    // sits in the highest used byte; positions beyond the register read zero.
    function automatic logic [7:0] tag_char(input logic [TAG_W-1:0] tag,
                                            input logic [POS_W-1:0] pos);
        logic [7:0] c;
        c = 8'd0;
        for (int k = 0; k < TAG_BYTES; k++) begin
            if (k <= TAG_CHARS - 1) begin
                if (POS_W'(TAG_CHARS - 1 - k) == pos) begin
                    c = tag[k*8 +: 8];
                end
            end
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/nmea_sentence_checker_unit.sv
// ----------------------------------------------------------------------------
// nmea_sentence_checker_unit
// Frames NMEA 0183 sentences byte by byte and checks tag and XOR checksum.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_valid, s_ready, s_rx_byte) takes one received byte per
// beat. Every accepted byte yields exactly one result beat on the output
// channel (m_valid, m_ready, m_*): the framing flags, which are set only on
// the LF that closes a sentence, and the running XOR checksum.
// A result follows its byte in the next cycle, one byte per cycle while
// the receiver takes results. Framing state is updated in the same cycle
// the byte is accepted; the one result register is the only pipeline stage.
// When the receiver stalls, the result register holds its beat and s_ready
// stays high only if that beat is being taken in the same cycle, so at most
// one result waits and none is lost.
// Reset (synchronous, aresetn low) returns framing to idle, clears the
// checksum state, empties the result register and loads the tag register
// with "GPGGA". cfg_wr_en writes cfg_wr_data into the tag register; write it
// only while no byte is in flight.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_unit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [nsc_pkg::TAG_W-1:0] cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_rx_byte,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_sentence_done,
    output logic                     m_sentence_valid,
    output logic                     m_tag_matched,
    output logic                     m_checksum_matched,
    output logic [7:0]               m_running_checksum
);

    logic [nsc_pkg::TAG_W-1:0] tag_reg;
    nsc_pkg::phase_t           phase_reg, phase_next;
    logic [7:0]                xor_reg, xor_next;
    logic [7:0]                rsum_reg, rsum_next;
    logic                      digits_ok_reg, digits_ok_next;
    logic [nsc_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      tag_ok_reg, tag_ok_next;

    logic       out_valid_reg;
    logic       done_reg, done_next;
    logic       tag_m_reg, tag_m_next;
    logic       ck_m_reg, ck_m_next;
    logic [7:0] cksum_reg;

    logic         accept;
    logic         pos_open;
    nsc_pkg::hex_t hex;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign pos_open = pos_reg < nsc_pkg::POS_W'(nsc_pkg::TAG_CHARS);
    assign hex      = nsc_pkg::hex_decode(s_rx_byte);

    always_comb begin
        phase_next     = phase_reg;
        xor_next       = xor_reg;
        rsum_next      = rsum_reg;
        digits_ok_next = digits_ok_reg;
        pos_next       = pos_reg;
        tag_ok_next    = tag_ok_reg;
        done_next      = 1'b0;
        tag_m_next     = 1'b0;
        ck_m_next      = 1'b0;

        if (s_rx_byte == nsc_pkg::CHAR_DOLLAR) begin
            phase_next     = nsc_pkg::PH_DATA;
            xor_next       = 8'd0;
            rsum_next      = 8'd0;
            digits_ok_next = 1'b1;
            pos_next       = '0;
            tag_ok_next    = 1'b1;
        end else begin
            case (phase_reg)
                nsc_pkg::PH_DATA: begin
                    if (s_rx_byte == nsc_pkg::CHAR_STAR) begin
                        // A sentence shorter than the tag cannot match it.
                        if (pos_open) begin
                            tag_ok_next = 1'b0;
                        end
                        phase_next = nsc_pkg::PH_HI;
                    end else begin
                        xor_next = xor_reg ^ s_rx_byte;
                        if (pos_open) begin
                            if (s_rx_byte != nsc_pkg::tag_char(tag_reg, pos_reg)) begin
                                tag_ok_next = 1'b0;
                            end
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
                nsc_pkg::PH_HI: begin
                    if (!hex.ok) begin
                        digits_ok_next = 1'b0;
                    end
                    rsum_next  = {hex.val, 4'd0};
                    phase_next = nsc_pkg::PH_LO;
                end
                nsc_pkg::PH_LO: begin
                    if (!hex.ok) begin
                        digits_ok_next = 1'b0;
                    end
                    rsum_next  = {rsum_reg[7:4], hex.val};
                    phase_next = nsc_pkg::PH_CR;
                end
                nsc_pkg::PH_CR: begin
                    phase_next = (s_rx_byte == nsc_pkg::CHAR_CR) ? nsc_pkg::PH_LF
                                                                 : nsc_pkg::PH_IDLE;
                end
                nsc_pkg::PH_LF: begin
                    if (s_rx_byte == nsc_pkg::CHAR_LF) begin
                        done_next  = 1'b1;
                        tag_m_next = tag_ok_reg;
                        ck_m_next  = digits_ok_reg && (rsum_reg == xor_reg);
                    end
                    phase_next = nsc_pkg::PH_IDLE;
                end
                default: begin
                    phase_next = nsc_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg       <= nsc_pkg::TAG_RESET;
            phase_reg     <= nsc_pkg::PH_IDLE;
            xor_reg       <= 8'd0;
            rsum_reg      <= 8'd0;
            digits_ok_reg <= 1'b0;
            pos_reg       <= '0;
            tag_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                tag_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg     <= phase_next;
                xor_reg       <= xor_next;
                rsum_reg      <= rsum_next;
                digits_ok_reg <= digits_ok_next;
                pos_reg       <= pos_next;
                tag_ok_reg    <= tag_ok_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            done_reg  <= done_next;
            tag_m_reg <= tag_m_next;
            ck_m_reg  <= ck_m_next;
            cksum_reg <= xor_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_sentence_done    = done_reg;
    assign m_tag_matched      = tag_m_reg;
    assign m_checksum_matched = ck_m_reg;
    assign m_sentence_valid   = tag_m_reg && ck_m_reg;
    assign m_running_checksum = cksum_reg;

endmodule

FILE: hw/rtl/nsc_checker.sv
// ----------------------------------------------------------------------------
// nsc_checker
// Port-level assertions for the NMEA sentence checker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nsc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_sentence_done,
    input logic       m_sentence_valid,
    input logic       m_tag_matched,
    input logic       m_checksum_matched,
    input logic [7:0] m_running_checksum
);

    // A waiting result must not be dropped before the receiver takes it.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_running_checksum))

    // Overall validity requires a closed sentence with both checks passing.
    `ASSERT_IMPLIES(a_valid_parts, aclk, aresetn, m_valid && m_sentence_valid, m_sentence_done && m_tag_matched && m_checksum_matched)

    // Match flags are only reported on the closing LF.
    `ASSERT_IMPLIES(a_flags_need_done, aclk, aresetn, m_valid && !m_sentence_done, !m_tag_matched && !m_checksum_matched)

    // An empty result register always lets a new byte in.
    `ASSERT_IMPLIES(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

    // Reset empties the result register.
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind nmea_sentence_checker_unit nsc_checker u_nsc_checker (.*);
